// File: hdl/sbd_pkg.sv
// Shared types, phase and field codes, and float widening for the spline blob decoder.
package sbd_pkg;

    // Parse phases
    localparam logic [4:0] P_H1        = 5'd0;
    localparam logic [4:0] P_H2        = 5'd1;
    localparam logic [4:0] P_PRESLOPE  = 5'd2;
    localparam logic [4:0] P_POSTSLOPE = 5'd3;
    localparam logic [4:0] P_LSTART    = 5'd4;
    localparam logic [4:0] P_LEND      = 5'd5;
    localparam logic [4:0] P_LPRE      = 5'd6;
    localparam logic [4:0] P_LPOST     = 5'd7;
    localparam logic [4:0] P_LOFF      = 5'd8;
    localparam logic [4:0] P_COUNT     = 5'd9;
    localparam logic [4:0] P_KFLAG     = 5'd10;
    localparam logic [4:0] P_KTIME     = 5'd11;
    localparam logic [4:0] P_KVAL      = 5'd12;
    localparam logic [4:0] P_KPREVAL   = 5'd13;
    localparam logic [4:0] P_KPREW     = 5'd14;
    localparam logic [4:0] P_KPOSTW    = 5'd15;
    localparam logic [4:0] P_KPRES     = 5'd16;
    localparam logic [4:0] P_KPOSTS    = 5'd17;
    localparam logic [4:0] P_KALGO     = 5'd18;
    localparam logic [4:0] P_KEND      = 5'd19;
    localparam logic [4:0] P_DONE      = 5'd20;

    // Result field codes
    localparam logic [4:0] C_VERSION  = 5'd0;
    localparam logic [4:0] C_VTYPE    = 5'd1;
    localparam logic [4:0] C_CURVE    = 5'd2;
    localparam logic [4:0] C_PREMODE  = 5'd3;
    localparam logic [4:0] C_POSTMODE = 5'd4;
    localparam logic [4:0] C_LOOPFLAG = 5'd5;
    localparam logic [4:0] C_PRESLOPE = 5'd6;
    localparam logic [4:0] C_POSTSLP  = 5'd7;
    localparam logic [4:0] C_LSTART   = 5'd8;
    localparam logic [4:0] C_LEND     = 5'd9;
    localparam logic [4:0] C_LPRE     = 5'd10;
    localparam logic [4:0] C_LPOST    = 5'd11;
    localparam logic [4:0] C_LOFF     = 5'd12;
    localparam logic [4:0] C_COUNT    = 5'd13;
    localparam logic [4:0] C_KDUAL    = 5'd14;
    localparam logic [4:0] C_KINTERP  = 5'd15;
    localparam logic [4:0] C_KTIME    = 5'd16;
    localparam logic [4:0] C_KVAL     = 5'd17;
    localparam logic [4:0] C_KPREVAL  = 5'd18;
    localparam logic [4:0] C_KPREW    = 5'd19;
    localparam logic [4:0] C_KPOSTW   = 5'd20;
    localparam logic [4:0] C_KPRES    = 5'd21;
    localparam logic [4:0] C_KPOSTS   = 5'd22;
    localparam logic [4:0] C_KPREALG  = 5'd23;
    localparam logic [4:0] C_KPOSTALG = 5'd24;
    localparam logic [4:0] C_END      = 5'd25;

    // Status codes
    localparam logic [1:0] S_OK       = 2'd0;
    localparam logic [1:0] S_TRUNC    = 2'd1;
    localparam logic [1:0] S_OVERSIZE = 2'd2;

    // Value types
    localparam logic [1:0] VT_FLOAT = 2'd2;
    localparam logic [1:0] VT_HALF  = 2'd3;

    localparam int NRES = 4;

    typedef struct packed {
        logic [4:0]  code;
        logic [63:0] value;
        logic [19:0] knot;
        logic [1:0]  status;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [2:0]           cnt;
        t_res [NRES-1:0]      res;
    } t_bundle;

    function automatic logic [3:0] val_bytes(input logic [1:0] vt);
        unique case (vt)
            VT_FLOAT: val_bytes = 4'd4;
            VT_HALF:  val_bytes = 4'd2;
            default:  val_bytes = 4'd8;
        endcase
    endfunction

    function automatic logic [3:0] field_size(input logic [4:0] ph, input logic [1:0] vt);
        unique case (ph)
            P_H1, P_H2, P_KFLAG, P_KALGO:           field_size = 4'd1;
            P_LPRE, P_LPOST, P_COUNT:               field_size = 4'd4;
            P_KVAL, P_KPREVAL, P_KPRES, P_KPOSTS:   field_size = val_bytes(vt);
            default:                                field_size = 4'd8;
        endcase
    endfunction

    // Widen float or half bits to double bits, exactly except that NaNs are made quiet
    function automatic logic [63:0] widen(input logic [63:0] v, input logic [1:0] vt);
        logic        s;
        logic [10:0] e;
        logic [51:0] m;
        logic [4:0]  k;
        logic        hit;
        s = 1'b0; e = 11'd0; m = 52'd0; k = 5'd0; hit = 1'b0;
        if (vt == VT_FLOAT) begin
            s = v[31];
            if (v[30:23] == 8'hff) begin
                e = 11'd2047;
                m = {v[22:0], 29'd0};
                if (v[22:0] != 23'd0) m[51] = 1'b1;
            end else if (v[30:23] == 8'h00) begin
                if (v[22:0] != 23'd0) begin
                    // find leading one of the subnormal fraction
                    for (int i = 22; i >= 0; i--) begin
                        if (!hit && v[i]) begin
                            hit = 1'b1;
                            k = 5'(23 - i);
                        end
                    end
                    e = 11'(11'd897 - 11'(k));
                    m = {23'(v[22:0] << k), 29'd0};
                end
            end else begin
                e = 11'(v[30:23]) + 11'd896;
                m = {v[22:0], 29'd0};
            end
            widen = {s, e, m};
        end else if (vt == VT_HALF) begin
            s = v[15];
            if (v[14:10] == 5'h1f) begin
                e = 11'd2047;
                m = {v[9:0], 42'd0};
                if (v[9:0] != 10'd0) m[51] = 1'b1;
            end else if (v[14:10] == 5'h00) begin
                if (v[9:0] != 10'd0) begin
                    for (int i = 9; i >= 0; i--) begin
                        if (!hit && v[i]) begin
                            hit = 1'b1;
                            k = 5'(10 - i);
                        end
                    end
                    e = 11'(11'd1009 - 11'(k));
                    m = {10'(v[9:0] << k), 42'd0};
                end
            end else begin
                e = 11'(v[14:10]) + 11'd1008;
                m = {v[9:0], 42'd0};
            end
            widen = {s, e, m};
        end else begin
            widen = v;
        end
    endfunction

endpackage

// File: hdl/spline_blob_decoder_unit.sv
// Top level of the spline blob decoder: config register, parser, queue and output stage.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[7:0]=data_byte, s_tlast=final_byte
//  m_*       out  m_tvalid/m_tready  m_tdata=value,knot,status; m_tuser=code; m_tlast=end
//  apb       in   psel/penable/pwrite/pready  addr 0: blob_length[19:0]
//
// One byte is taken per cycle while the four-bundle queue has room.
// Each byte yields zero to four results, sent one per cycle from the output register while m_tready is high.
// A byte's results pass through a queue entry and then the output register.
// Reset is synchronous and active low; it clears parse state and the queue.
// A stalled output fills the queue, after which s_tready drops.
module spline_blob_decoder_unit #(
    parameter int LENGTH_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // [63:0] field_value, [83:64] knot_number, [85:84] status
    output logic [7:0]  m_tuser,    // [4:0] field_code
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] A_BLOB_LEN = 3'd0;

    logic [19:0]      r_blob_len;
    sbd_pkg::t_bundle w_bundle, w_head;
    sbd_pkg::t_res    w_res;
    logic             w_take, w_push, w_pop, w_empty, w_full;

    // Config register
    assign pready = 1'b1;
    assign prdata = (paddr == A_BLOB_LEN) ? {12'd0, r_blob_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blob_len <= '0;
        end else if (psel && penable && pwrite && pready && paddr == A_BLOB_LEN) begin
            r_blob_len <= pwdata[19:0];
        end
    end

    assign s_tready = !w_full;
    assign w_take   = s_tvalid && s_tready;
    assign w_push   = w_take && (w_bundle.cnt != 3'd0);

    sbd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take), .i_byte(s_tdata),
        .i_final(s_tlast), .i_blob_len(r_blob_len), .o_bundle(w_bundle)
    );

    sbd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_bundle),
        .i_pop(w_pop), .o_head(w_head), .o_empty(w_empty), .o_full(w_full)
    );

    sbd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(w_head), .i_empty(w_empty),
        .o_pop(w_pop), .i_ready(m_tready), .o_valid(m_tvalid), .o_res(w_res)
    );

    assign m_tdata = {2'b00, w_res.status, w_res.knot, w_res.value};
    assign m_tuser = {3'b000, w_res.code};
    assign m_tlast = w_res.last;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue push while full");
    a_end_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser[4:0] == sbd_pkg::C_END))
        else $error("end marker on non-end field");
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[85:84] == sbd_pkg::S_OK))
        else $error("error status outside end result");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("queue pop while empty");
`endif

endmodule

// File: hdl/sbd_front.sv
// Front end: byte parser that turns each byte into a bundle of up to four results.
module sbd_front #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_final,
    input  logic [19:0]         i_blob_len,
    output sbd_pkg::t_bundle    o_bundle
);

    logic [4:0]             r_phase, n_phase;
    logic [2:0]             r_fbc, n_fbc;
    logic [63:0]            r_asm, n_asm;
    logic [3:0]             r_ver, n_ver;
    logic [1:0]             r_vt, n_vt;
    logic                   r_herm, n_herm;
    logic [2:0]             r_pre, n_pre;
    logic [2:0]             r_post, n_post;
    logic                   r_loop, n_loop;
    logic [31:0]            r_kleft, n_kleft;
    logic [LENGTH_BITS-1:0] r_kcnt, n_kcnt;
    logic                   r_dual, n_dual;
    logic [LENGTH_BITS-1:0] r_bl, n_bl;

    // Parse one byte
    always_comb begin
        sbd_pkg::t_bundle bnd;
        logic [2:0]   c;
        logic [3:0]   size;
        logic [63:0]  v;
        logic [63:0]  w;
        logic [19:0]  kn;
        logic [4:0]   p;
        logic [5:0]   mk;
        logic [37:0]  prod;
        logic         done;
        bnd = '0; c = 3'd0; v = '0; w = '0; p = sbd_pkg::P_DONE; mk = '0; prod = '0;
        done = 1'b0;
        n_phase = r_phase; n_fbc = r_fbc; n_asm = r_asm; n_ver = r_ver; n_vt = r_vt;
        n_herm = r_herm; n_pre = r_pre; n_post = r_post; n_loop = r_loop;
        n_kleft = r_kleft; n_kcnt = r_kcnt; n_dual = r_dual; n_bl = r_bl;
        kn = 20'(r_kcnt);
        size = sbd_pkg::field_size(r_phase, r_vt);

        if (r_phase != sbd_pkg::P_DONE) begin
            if (r_phase == sbd_pkg::P_H1 && r_fbc == 3'd0) n_bl = LENGTH_BITS'(i_blob_len);
            if (r_fbc == 3'd0 && n_bl < LENGTH_BITS'(size)) begin
                bnd.res[c[1:0]] = '{sbd_pkg::C_END, 64'd0, kn, sbd_pkg::S_TRUNC, 1'b1};
                c = c + 3'd1;
                n_phase = sbd_pkg::P_DONE;
            end else begin
                v = r_asm | (64'(i_byte) << {r_fbc, 3'b000});
                n_asm = v;
                if (n_bl != '0) n_bl = n_bl - 1'b1;
                n_fbc = r_fbc + 3'd1;
                if ({1'b0, n_fbc} >= size || r_fbc == 3'd7) begin
                    n_fbc = 3'd0;
                    n_asm = '0;
                    w = sbd_pkg::widen(v, r_vt);
                    unique case (r_phase)
                        sbd_pkg::P_H1: begin
                            n_ver = v[3:0]; n_vt = v[5:4]; n_herm = v[7];
                            bnd.res[0] = '{sbd_pkg::C_VERSION, 64'(v[3:0]), 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            bnd.res[1] = '{sbd_pkg::C_VTYPE,
                                           (v[5:4] == 2'd0) ? 64'd1 : 64'(v[5:4]), 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            bnd.res[2] = '{sbd_pkg::C_CURVE, 64'(v[7]), 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            c = 3'd3;
                            p = sbd_pkg::P_H2;
                        end
                        sbd_pkg::P_H2: begin
                            n_pre = v[2:0]; n_post = v[5:3]; n_loop = v[6];
                            bnd.res[0] = '{sbd_pkg::C_PREMODE, 64'(v[2:0]), 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            bnd.res[1] = '{sbd_pkg::C_POSTMODE, 64'(v[5:3]), 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            bnd.res[2] = '{sbd_pkg::C_LOOPFLAG, 64'(v[6]), 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            c = 3'd3;
                            p = (v[2:0] == 3'd3) ? sbd_pkg::P_PRESLOPE :
                                (v[5:3] == 3'd3) ? sbd_pkg::P_POSTSLOPE :
                                v[6] ? sbd_pkg::P_LSTART : sbd_pkg::P_COUNT;
                        end
                        sbd_pkg::P_PRESLOPE: begin
                            bnd.res[0] = '{sbd_pkg::C_PRESLOPE, v, 20'd0, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1;
                            p = (r_post == 3'd3) ? sbd_pkg::P_POSTSLOPE :
                                r_loop ? sbd_pkg::P_LSTART : sbd_pkg::P_COUNT;
                        end
                        sbd_pkg::P_POSTSLOPE: begin
                            bnd.res[0] = '{sbd_pkg::C_POSTSLP, v, 20'd0, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1;
                            p = r_loop ? sbd_pkg::P_LSTART : sbd_pkg::P_COUNT;
                        end
                        sbd_pkg::P_LSTART: begin
                            bnd.res[0] = '{sbd_pkg::C_LSTART, v, 20'd0, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_LEND;
                        end
                        sbd_pkg::P_LEND: begin
                            bnd.res[0] = '{sbd_pkg::C_LEND, v, 20'd0, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_LPRE;
                        end
                        sbd_pkg::P_LPRE: begin
                            bnd.res[0] = '{sbd_pkg::C_LPRE, {{32{v[31]}}, v[31:0]}, 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_LPOST;
                        end
                        sbd_pkg::P_LPOST: begin
                            bnd.res[0] = '{sbd_pkg::C_LPOST, {{32{v[31]}}, v[31:0]}, 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_LOFF;
                        end
                        sbd_pkg::P_LOFF: begin
                            bnd.res[0] = '{sbd_pkg::C_LOFF, v, 20'd0, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_COUNT;
                        end
                        sbd_pkg::P_COUNT: begin
                            bnd.res[0] = '{sbd_pkg::C_COUNT, {32'd0, v[31:0]}, 20'd0,
                                           sbd_pkg::S_OK, 1'b0};
                            c = 3'd1;
                            n_kleft = v[31:0];
                            n_kcnt = '0;
                            // minimum knot record size
                            mk = 6'd9 + 6'(3 * sbd_pkg::val_bytes(r_vt))
                               + (r_herm ? 6'd0 : 6'd16) + ((r_ver > 4'd1) ? 6'd1 : 6'd0);
                            prod = 38'(v[31:0]) * 38'(mk);
                            p = sbd_pkg::P_KFLAG;
                            if (prod > 38'(n_bl)) begin
                                bnd.res[1] = '{sbd_pkg::C_END, 64'd0, 20'd0,
                                               sbd_pkg::S_OVERSIZE, 1'b1};
                                c = 3'd2; done = 1'b1;
                            end else if (v[31:0] == 32'd0) begin
                                bnd.res[1] = '{sbd_pkg::C_END, 64'd0, 20'd0,
                                               sbd_pkg::S_OK, 1'b1};
                                c = 3'd2; done = 1'b1;
                            end
                        end
                        sbd_pkg::P_KFLAG: begin
                            n_dual = v[0];
                            bnd.res[0] = '{sbd_pkg::C_KDUAL, 64'(v[0]), kn, sbd_pkg::S_OK, 1'b0};
                            bnd.res[1] = '{sbd_pkg::C_KINTERP, 64'(v[2:1]), kn,
                                           sbd_pkg::S_OK, 1'b0};
                            c = 3'd2; p = sbd_pkg::P_KTIME;
                        end
                        sbd_pkg::P_KTIME: begin
                            bnd.res[0] = '{sbd_pkg::C_KTIME, v, kn, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_KVAL;
                        end
                        sbd_pkg::P_KVAL: begin
                            bnd.res[0] = '{sbd_pkg::C_KVAL, w, kn, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1;
                            if (!r_dual) begin
                                bnd.res[1] = '{sbd_pkg::C_KPREVAL, w, kn, sbd_pkg::S_OK, 1'b0};
                                c = 3'd2;
                            end
                            p = r_dual ? sbd_pkg::P_KPREVAL :
                                !r_herm ? sbd_pkg::P_KPREW : sbd_pkg::P_KPRES;
                        end
                        sbd_pkg::P_KPREVAL: begin
                            bnd.res[0] = '{sbd_pkg::C_KPREVAL, w, kn, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1;
                            p = !r_herm ? sbd_pkg::P_KPREW : sbd_pkg::P_KPRES;
                        end
                        sbd_pkg::P_KPREW: begin
                            bnd.res[0] = '{sbd_pkg::C_KPREW, v, kn, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_KPOSTW;
                        end
                        sbd_pkg::P_KPOSTW: begin
                            bnd.res[0] = '{sbd_pkg::C_KPOSTW, v, kn, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_KPRES;
                        end
                        sbd_pkg::P_KPRES: begin
                            bnd.res[0] = '{sbd_pkg::C_KPRES, w, kn, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1; p = sbd_pkg::P_KPOSTS;
                        end
                        sbd_pkg::P_KPOSTS: begin
                            bnd.res[0] = '{sbd_pkg::C_KPOSTS, w, kn, sbd_pkg::S_OK, 1'b0};
                            c = 3'd1;
                            p = (r_ver > 4'd1) ? sbd_pkg::P_KALGO : sbd_pkg::P_KEND;
                        end
                        default: begin
                            bnd.res[0] = '{sbd_pkg::C_KPREALG, 64'(v[3:0]), kn,
                                           sbd_pkg::S_OK, 1'b0};
                            bnd.res[1] = '{sbd_pkg::C_KPOSTALG, 64'(v[7:4]), kn,
                                           sbd_pkg::S_OK, 1'b0};
                            c = 3'd2; p = sbd_pkg::P_KEND;
                        end
                    endcase
                    if (done) begin
                        n_phase = sbd_pkg::P_DONE;
                    end else if (p == sbd_pkg::P_KEND) begin
                        // close the knot
                        n_kcnt = r_kcnt + 1'b1;
                        n_kleft = r_kleft - 32'd1;
                        if (n_kleft == 32'd0) begin
                            bnd.res[c[1:0]] = '{sbd_pkg::C_END, 64'd0, 20'(n_kcnt),
                                                sbd_pkg::S_OK, 1'b1};
                            c = c + 3'd1;
                            n_phase = sbd_pkg::P_DONE;
                        end else begin
                            n_phase = sbd_pkg::P_KFLAG;
                        end
                    end else begin
                        n_phase = p;
                    end
                end
            end
        end

        // last byte: end the blob if still open, then restart
        if (i_final) begin
            if (n_phase != sbd_pkg::P_DONE) begin
                bnd.res[c[1:0]] = '{sbd_pkg::C_END, 64'd0, 20'(n_kcnt),
                                    sbd_pkg::S_TRUNC, 1'b1};
                c = c + 3'd1;
            end
            n_phase = sbd_pkg::P_H1;
            n_fbc = 3'd0;
            n_asm = '0;
            n_kleft = '0;
            n_kcnt = '0;
            n_dual = 1'b0;
        end
        bnd.cnt = c;
        o_bundle = bnd;
    end

    // Advance parse state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sbd_pkg::P_H1;
            r_fbc   <= '0;
            r_asm   <= '0;
            r_ver   <= '0;
            r_vt    <= '0;
            r_herm  <= 1'b0;
            r_pre   <= '0;
            r_post  <= '0;
            r_loop  <= 1'b0;
            r_kleft <= '0;
            r_kcnt  <= '0;
            r_dual  <= 1'b0;
            r_bl    <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_fbc   <= n_fbc;
            r_asm   <= n_asm;
            r_ver   <= n_ver;
            r_vt    <= n_vt;
            r_herm  <= n_herm;
            r_pre   <= n_pre;
            r_post  <= n_post;
            r_loop  <= n_loop;
            r_kleft <= n_kleft;
            r_kcnt  <= n_kcnt;
            r_dual  <= n_dual;
            r_bl    <= n_bl;
        end
    end

endmodule

// File: hdl/sbd_queue.sv
// Short bundle queue between parser and output sequencer.
module sbd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sbd_pkg::t_bundle  i_data,
    input  logic              i_pop,
    output sbd_pkg::t_bundle  o_head,
    output logic              o_empty,
    output logic              o_full
);

    localparam int DEPTH = 4;

    sbd_pkg::t_bundle r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == 3'd0);
    assign o_full  = (r_cnt == 3'(DEPTH));

    // Store pushed bundles
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (i_push ? 3'd1 : 3'd0) - (i_pop ? 3'd1 : 3'd0);
        end
    end

endmodule

// File: hdl/sbd_back.sv
// Back end: walks each queued bundle and presents one result per word in an output register.
module sbd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbd_pkg::t_bundle  i_head,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output sbd_pkg::t_res     o_res
);

    logic [1:0]    r_idx;
    logic          r_valid;
    sbd_pkg::t_res r_res;
    logic          w_load;
    logic          w_lastslot;

    assign w_load     = !i_empty && (!r_valid || i_ready);
    assign w_lastslot = ({1'b0, r_idx} == (i_head.cnt - 3'd1));
    assign o_pop      = w_load && w_lastslot;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    // Hold the result until taken, load the next slot when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_lastslot ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_res <= i_head.res[r_idx];
    end

endmodule

// File: verif/tb_spline_blob_decoder_unit.sv
// Self-checking testbench for the spline blob decoder: blob stimulus, field prediction, checks.
`timescale 1ns / 100ps

module tb_spline_blob_decoder_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;    // [63:0] field_value, [83:64] knot_number, [85:84] status
    logic [7:0]  m_tuser;    // [4:0] field_code
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [2:0] ADDR_BLOB_LENGTH = 3'd0;

    spline_blob_decoder_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    // Expected decoded fields, oldest first
    sbd_pkg::t_res field_q[$];
    logic [7:0]  blob_q[$];
    int          errors;
    int          bytes_sent;
    int          fields_seen;
    int          blobs_sent;
    int          burst_left;

    // Shadow copy of the decoder state
    logic [4:0]  sh_phase;
    int unsigned sh_fbc;
    logic [63:0] sh_asm;
    logic [3:0]  sh_ver;
    logic [1:0]  sh_vt;
    logic        sh_herm;
    logic [2:0]  sh_pre;
    logic [2:0]  sh_post;
    logic        sh_loop;
    logic [31:0] sh_kleft;
    logic [19:0] sh_knot;
    logic        sh_dual;
    logic [19:0] sh_bleft;
    logic [19:0] sh_blen;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("spline_blob_decoder_unit: mismatch");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("  error at %0t: %s got %h want %h", $time, what, got, want);
        errors++;
    endtask

    // ---------------- prediction ----------------
    function automatic int unsigned value_bytes();
        if (sh_vt == sbd_pkg::VT_FLOAT) return 4;
        if (sh_vt == sbd_pkg::VT_HALF) return 2;
        return 8;
    endfunction

    function automatic int unsigned phase_bytes(input logic [4:0] ph);
        case (ph)
            sbd_pkg::P_H1, sbd_pkg::P_H2, sbd_pkg::P_KFLAG, sbd_pkg::P_KALGO: return 1;
            sbd_pkg::P_LPRE, sbd_pkg::P_LPOST, sbd_pkg::P_COUNT: return 4;
            sbd_pkg::P_KVAL, sbd_pkg::P_KPREVAL, sbd_pkg::P_KPRES,
            sbd_pkg::P_KPOSTS: return value_bytes();
            default: return 8;
        endcase
    endfunction

    function automatic logic phase_absent(input logic [4:0] ph);
        case (ph)
            sbd_pkg::P_PRESLOPE: return sh_pre != 3'd3;
            sbd_pkg::P_POSTSLOPE: return sh_post != 3'd3;
            sbd_pkg::P_LSTART, sbd_pkg::P_LEND, sbd_pkg::P_LPRE, sbd_pkg::P_LPOST,
            sbd_pkg::P_LOFF: return !sh_loop;
            sbd_pkg::P_KPREVAL: return !sh_dual;
            sbd_pkg::P_KPREW, sbd_pkg::P_KPOSTW: return sh_herm;
            sbd_pkg::P_KALGO: return sh_ver <= 4'd1;
            default: return 1'b0;
        endcase
    endfunction

    // Widen float or half bits to double bits, keeping NaN payloads quiet
    function automatic logic [63:0] to_double(input logic [63:0] v);
        logic [63:0] s, e, m;
        int          k;
        k = 0;
        if (sh_vt == sbd_pkg::VT_FLOAT) begin
            s = v[31]; e = v[30:23]; m = v[22:0];
            if (e == 64'd255) begin
                e = 64'd2047; m = m << 29;
                if (m != 0) m[51] = 1'b1;
            end else if (e == 64'd0) begin
                if (m != 0) begin
                    while (!m[23]) begin m = m << 1; k++; end
                    e = 64'd897 - k; m = {41'd0, m[22:0]} << 29;
                end
            end else begin
                e = e + 64'd896; m = m << 29;
            end
            return (s << 63) | (e << 52) | m;
        end
        if (sh_vt == sbd_pkg::VT_HALF) begin
            s = v[15]; e = v[14:10]; m = v[9:0];
            if (e == 64'd31) begin
                e = 64'd2047; m = m << 42;
                if (m != 0) m[51] = 1'b1;
            end else if (e == 64'd0) begin
                if (m != 0) begin
                    while (!m[10]) begin m = m << 1; k++; end
                    e = 64'd1009 - k; m = {54'd0, m[9:0]} << 42;
                end
            end else begin
                e = e + 64'd1008; m = m << 42;
            end
            return (s << 63) | (e << 52) | m;
        end
        return v;
    endfunction

    task automatic expect_field(input logic [4:0] code, input logic [63:0] val,
                                input logic [19:0] knot, input logic [1:0] st, input logic last);
        sbd_pkg::t_res r;
        r.code = code; r.value = val; r.knot = knot; r.status = st; r.last = last;
        field_q = {field_q, r};
    endtask

    task automatic close_blob(input logic [1:0] st);
        expect_field(sbd_pkg::C_END, 64'd0, sh_knot, st, 1'b1);
        sh_phase = sbd_pkg::P_DONE;
    endtask

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Act on one fully assembled field
    task automatic field_done(input logic [63:0] v);
        logic [19:0] kn;
        logic [63:0] w, mk;
        logic [4:0]  p;
        kn = sh_knot;
        case (sh_phase)
            sbd_pkg::P_H1: begin
                sh_ver = v[3:0]; sh_vt = v[5:4]; sh_herm = v[7];
                expect_field(sbd_pkg::C_VERSION, sh_ver, 0, sbd_pkg::S_OK, 0);
                expect_field(sbd_pkg::C_VTYPE, (sh_vt == 2'd0) ? 64'd1 : sh_vt, 0,
                             sbd_pkg::S_OK, 0);
                expect_field(sbd_pkg::C_CURVE, sh_herm, 0, sbd_pkg::S_OK, 0);
            end
            sbd_pkg::P_H2: begin
                sh_pre = v[2:0]; sh_post = v[5:3]; sh_loop = v[6];
                expect_field(sbd_pkg::C_PREMODE, sh_pre, 0, sbd_pkg::S_OK, 0);
                expect_field(sbd_pkg::C_POSTMODE, sh_post, 0, sbd_pkg::S_OK, 0);
                expect_field(sbd_pkg::C_LOOPFLAG, sh_loop, 0, sbd_pkg::S_OK, 0);
            end
            sbd_pkg::P_PRESLOPE:  expect_field(sbd_pkg::C_PRESLOPE, v, 0, sbd_pkg::S_OK, 0);
            sbd_pkg::P_POSTSLOPE: expect_field(sbd_pkg::C_POSTSLP, v, 0, sbd_pkg::S_OK, 0);
            sbd_pkg::P_LSTART:    expect_field(sbd_pkg::C_LSTART, v, 0, sbd_pkg::S_OK, 0);
            sbd_pkg::P_LEND:      expect_field(sbd_pkg::C_LEND, v, 0, sbd_pkg::S_OK, 0);
            sbd_pkg::P_LPRE:      expect_field(sbd_pkg::C_LPRE, sext32(v), 0, sbd_pkg::S_OK, 0);
            sbd_pkg::P_LPOST:     expect_field(sbd_pkg::C_LPOST, sext32(v), 0, sbd_pkg::S_OK, 0);
            sbd_pkg::P_LOFF:      expect_field(sbd_pkg::C_LOFF, v, 0, sbd_pkg::S_OK, 0);
            sbd_pkg::P_COUNT: begin
                v = {32'd0, v[31:0]};
                expect_field(sbd_pkg::C_COUNT, v, 0, sbd_pkg::S_OK, 0);
                sh_kleft = v[31:0];
                sh_knot = 0;
                mk = 64'd9 + 3 * value_bytes();
                if (!sh_herm) mk += 16;
                if (sh_ver > 4'd1) mk += 1;
                if (v > sh_bleft / mk) begin close_blob(sbd_pkg::S_OVERSIZE); return; end
                if (v == 0) begin close_blob(sbd_pkg::S_OK); return; end
            end
            sbd_pkg::P_KFLAG: begin
                sh_dual = v[0];
                expect_field(sbd_pkg::C_KDUAL, sh_dual, kn, sbd_pkg::S_OK, 0);
                expect_field(sbd_pkg::C_KINTERP, v[2:1], kn, sbd_pkg::S_OK, 0);
            end
            sbd_pkg::P_KTIME: expect_field(sbd_pkg::C_KTIME, v, kn, sbd_pkg::S_OK, 0);
            sbd_pkg::P_KVAL: begin
                w = to_double(v);
                expect_field(sbd_pkg::C_KVAL, w, kn, sbd_pkg::S_OK, 0);
                if (!sh_dual) expect_field(sbd_pkg::C_KPREVAL, w, kn, sbd_pkg::S_OK, 0);
            end
            sbd_pkg::P_KPREVAL:
                expect_field(sbd_pkg::C_KPREVAL, to_double(v), kn, sbd_pkg::S_OK, 0);
            sbd_pkg::P_KPREW:  expect_field(sbd_pkg::C_KPREW, v, kn, sbd_pkg::S_OK, 0);
            sbd_pkg::P_KPOSTW: expect_field(sbd_pkg::C_KPOSTW, v, kn, sbd_pkg::S_OK, 0);
            sbd_pkg::P_KPRES:
                expect_field(sbd_pkg::C_KPRES, to_double(v), kn, sbd_pkg::S_OK, 0);
            sbd_pkg::P_KPOSTS:
                expect_field(sbd_pkg::C_KPOSTS, to_double(v), kn, sbd_pkg::S_OK, 0);
            default: begin
                expect_field(sbd_pkg::C_KPREALG, v[3:0], kn, sbd_pkg::S_OK, 0);
                expect_field(sbd_pkg::C_KPOSTALG, v[7:4], kn, sbd_pkg::S_OK, 0);
            end
        endcase
        // Advance to the next present field, wrapping to the next knot
        p = sh_phase + 5'd1;
        while (p < sbd_pkg::P_KEND && phase_absent(p)) p++;
        if (p >= sbd_pkg::P_KEND) begin
            sh_knot = sh_knot + 20'd1;
            sh_kleft = sh_kleft - 32'd1;
            if (sh_kleft == 0) begin close_blob(sbd_pkg::S_OK); return; end
            p = sbd_pkg::P_KFLAG;
        end
        sh_phase = p;
    endtask

    task automatic restart_blob();
        sh_phase = sbd_pkg::P_H1; sh_fbc = 0; sh_asm = 0;
        sh_kleft = 0; sh_knot = 0; sh_dual = 0;
    endtask

    task automatic predict_word(input logic [7:0] b, input logic fin);
        int unsigned sz;
        logic [63:0] v;
        if (sh_phase != sbd_pkg::P_DONE) begin
            if (sh_phase == sbd_pkg::P_H1 && sh_fbc == 0) sh_bleft = sh_blen;
            sz = phase_bytes(sh_phase);
            if (sh_fbc == 0 && sh_bleft < sz) begin
                close_blob(sbd_pkg::S_TRUNC);
            end else begin
                sh_asm = sh_asm | (64'(b) << (8 * (sh_fbc & 7)));
                if (sh_bleft > 0) sh_bleft--;
                sh_fbc++;
                if (sh_fbc >= sz) begin
                    v = sh_asm;
                    sh_fbc = 0;
                    sh_asm = 0;
                    field_done(v);
                end
            end
        end
        if (fin) begin
            if (sh_phase != sbd_pkg::P_DONE) close_blob(sbd_pkg::S_TRUNC);
            restart_blob();
        end
    endtask

    // ---------------- drivers ----------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_BLOB_LENGTH) sh_blen = data[19:0];
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Send one word in bursts with random gaps; called and returns at a falling edge
    task automatic send_word(input logic [7:0] b, input logic fin);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        s_tdata = b; s_tlast = fin; s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        predict_word(b, fin);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (field_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Stream the first n words of blob_q with the given length setting
    task automatic stream_blob(input logic [19:0] len, input int n);
        wait_drained();
        apb_write(ADDR_BLOB_LENGTH, {12'd0, len});
        for (int i = 0; i < n; i++) send_word(blob_q[i], i == n - 1);
        s_tvalid = 1'b0;
        blobs_sent++;
    endtask

    // ---------------- blob construction ----------------
    task automatic add_le(input int n, input logic [63:0] v);
        for (int i = 0; i < n; i++) blob_q = {blob_q, v[8*i +: 8]};
    endtask

    task automatic add_rand(input int n);
        add_le(n, {$urandom, $urandom});
    endtask

    // Value scalar, often a special case: infinity or NaN, zero or subnormal
    task automatic add_scalar(input logic [1:0] vt);
        logic [63:0] v;
        int          kind;
        v = {$urandom, $urandom};
        kind = $urandom_range(0, 4);
        if (vt == sbd_pkg::VT_FLOAT) begin
            if (kind == 1) v[30:23] = 8'hff;
            if (kind == 2) v[30:23] = 8'h00;
            if (kind == 3) v[22:0] = 23'd0;
            if (kind == 4) v[30:0] = 31'd1 << $urandom_range(0, 22);
            add_le(4, v);
        end else if (vt == sbd_pkg::VT_HALF) begin
            if (kind == 1) v[14:10] = 5'h1f;
            if (kind == 2) v[14:10] = 5'h00;
            if (kind == 3) v[9:0] = 10'd0;
            if (kind == 4) v[14:0] = 15'd1 << $urandom_range(0, 9);
            add_le(2, v);
        end else begin
            add_le(8, v);
        end
    endtask

    task automatic build_blob(input logic [3:0] ver, input logic [1:0] vt, input logic herm,
                              input logic [2:0] pre, input logic [2:0] post, input logic lp,
                              input logic [31:0] count, input int knots);
        logic [7:0] flag;
        blob_q.delete();
        blob_q = {blob_q, {herm, 1'($urandom), vt, ver}};
        blob_q = {blob_q, {1'($urandom), lp, post, pre}};
        if (pre == 3'd3) add_rand(8);
        if (post == 3'd3) add_rand(8);
        if (lp) begin
            add_rand(8); add_rand(8); add_rand(4); add_rand(4); add_rand(8);
        end
        add_le(4, count);
        for (int k = 0; k < knots; k++) begin
            flag = $urandom;
            blob_q = {blob_q, flag};
            add_rand(8);
            add_scalar(vt);
            if (flag[0]) add_scalar(vt);
            if (!herm) begin add_rand(8); add_rand(8); end
            add_scalar(vt);
            add_scalar(vt);
            if (ver > 4'd1) add_rand(1);
        end
    endtask

    // ---------------- checking ----------------
    always @(posedge i_clk) begin
        sbd_pkg::t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            fields_seen++;
            if (field_q.size() == 0) begin
                report("unexpected field code", m_tuser[4:0], 0);
            end else begin
                want = field_q.pop_front();
                if (m_tuser[4:0] != want.code) report("field_code", m_tuser[4:0], want.code);
                if (m_tdata[63:0] != want.value) report("field_value", m_tdata[63:0], want.value);
                if (m_tdata[83:64] != want.knot) report("knot_number", m_tdata[83:64], want.knot);
                if (m_tdata[85:84] != want.status) report("status", m_tdata[85:84], want.status);
                if (m_tlast != want.last) report("end_of_blob", m_tlast, want.last);
            end
        end
    end

    // Receiver stall pattern: runs of always-ready, random and heavy stalling
    initial begin
        int mode;
        int run;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            run = $urandom_range(10, 60);
            repeat (run) begin
                @(negedge i_clk);
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = $urandom_range(0, 1);
                    default: m_tready = ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_short_blobs();
        // zero length: first word already truncated
        blob_q.delete(); blob_q = {blob_q, 8'h00};
        stream_blob(20'd0, 1);
        // zero knots, then trailing words ignored
        build_blob(4'd0, 2'd0, 1'b0, 3'd0, 3'd1, 1'b0, 32'd0, 0);
        add_rand(3);
        stream_blob(20'd6, blob_q.size());
        // all header bits set, cut by final word inside the loop block
        build_blob(4'd15, sbd_pkg::VT_HALF, 1'b1, 3'd7, 3'd7, 1'b1, 32'd1, 0);
        blob_q[0] = 8'hff; blob_q[1] = 8'hff;
        stream_blob(20'hfffff, 5);
    endtask

    task automatic test_count_limits();
        // oversized count at the largest length
        build_blob(4'd1, sbd_pkg::VT_FLOAT, 1'b1, 3'd2, 3'd4, 1'b0, 32'hffffffff, 0);
        stream_blob(20'hfffff, blob_q.size());
        // length too short for the count field
        build_blob(4'd2, sbd_pkg::VT_HALF, 1'b0, 3'd3, 3'd3, 1'b0, 32'd1, 0);
        stream_blob(20'd19, blob_q.size());
    endtask

    task automatic test_random_blobs();
        int          kind, knots, n;
        logic [3:0]  ver;
        logic [1:0]  vt;
        logic [2:0]  pre, post;
        logic [31:0] count;
        logic [19:0] len;
        while (bytes_sent < 230) begin
            ver = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
            vt = $urandom;
            pre = ($urandom_range(0, 1) == 0) ? 3'd3 : 3'($urandom);
            post = ($urandom_range(0, 1) == 0) ? 3'd3 : 3'($urandom);
            knots = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
            kind = $urandom_range(0, 19);
            count = (kind == 19) ? $urandom : 32'(knots);
            build_blob(ver, vt, 1'($urandom), pre, post, ($urandom_range(0, 2) == 0),
                       count, knots);
            n = blob_q.size();
            len = n;
            if (kind < 13) begin
                // well formed, maybe with spare length and trailing words
                if ($urandom_range(0, 1)) len = n + $urandom_range(0, 40);
                if ($urandom_range(0, 2) == 0) begin
                    add_rand($urandom_range(1, 3));
                    n = blob_q.size();
                end
            end else if (kind < 16) begin
                len = $urandom_range(0, n - 1);
            end else if (kind < 19) begin
                n = $urandom_range(1, n - 1);
            end
            stream_blob(len, n);
        end
    endtask

    initial begin
        errors = 0; bytes_sent = 0; fields_seen = 0; blobs_sent = 0; burst_left = 0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = 8'd0; s_tlast = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 3'd0; pwdata = 32'd0;
        sh_blen = 0; sh_bleft = 0; sh_ver = 0; sh_vt = 0; sh_herm = 0;
        sh_pre = 0; sh_post = 0; sh_loop = 0;
        restart_blob();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_short_blobs();
        test_count_limits();
        test_random_blobs();

        wait_drained();
        repeat (20) @(negedge i_clk);
        $display("Sent %0d blobs, %0d words; checked %0d decoded fields.",
                 blobs_sent, bytes_sent, fields_seen);
        $display("Covered truncation, oversized counts, trailing words and all value types.");
        if (errors == 0 && field_q.size() == 0) begin
            $display("spline_blob_decoder_unit: match");
        end else begin
            $display("spline_blob_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/sbd_pkg.sv
hdl/sbd_front.sv
hdl/sbd_queue.sv
hdl/sbd_back.sv
hdl/spline_blob_decoder_unit.sv
verif/tb_spline_blob_decoder_unit.sv
